// ===== hdl/longest_distinct_run_assert.svh =====
// assertion macros for the longest distinct run block
// expects i_clk and i_rst_n in the scope of each use
`ifndef LONGEST_DISTINCT_RUN_ASSERT_SVH
`define LONGEST_DISTINCT_RUN_ASSERT_SVH

// same-cycle implication, off while in reset
`define LDR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ldr assertion failed");

// next-cycle implication, off while in reset
`define LDR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ldr assertion failed");

`endif

// ===== hdl/ldr_pkg.sv =====
// shared types, sizes and helper functions of the longest distinct run block
// no dependencies
`default_nettype none

package ldr_pkg;

    localparam int POS_BITS    = 16;
    localparam int ALPHABET    = 256;
    localparam int SYM_IN_BITS = 8;
    localparam int SYM_BITS    = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
    localparam int OUT_BITS    = 16;
    localparam int FOLD_BITS   = SYM_IN_BITS + 9;

    typedef logic [SYM_IN_BITS-1:0] t_sym_in;
    typedef logic [SYM_BITS-1:0]    t_sym;
    typedef logic [POS_BITS-1:0]    t_pos;
    typedef logic [OUT_BITS-1:0]    t_len;

    // seen-mark update request from the datapath
    typedef struct packed {
        logic clr;
        logic set;
        t_sym addr;
    } t_seen_req;

    // fold an input byte into the alphabet by restoring remainder steps
    function automatic t_sym fold_sym(input t_sym_in s);
        logic [FOLD_BITS-1:0] v;
        v = FOLD_BITS'(s);
        for (int k = SYM_IN_BITS - 1; k >= 0; k--) begin
            if (v >= (FOLD_BITS'(ALPHABET) << k)) begin
                v = v - (FOLD_BITS'(ALPHABET) << k);
            end
        end
        return t_sym'(v);
    endfunction

    // clamp a position-wide length to the output width
    function automatic t_len sat_len(input t_pos v);
        logic [POS_BITS+OUT_BITS-1:0] w;
        w = (POS_BITS + OUT_BITS)'(v);
        if (w > (POS_BITS + OUT_BITS)'({OUT_BITS{1'b1}})) begin
            return {OUT_BITS{1'b1}};
        end
        return w[OUT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ldr_if.sv =====
// valid/ready channel interfaces for symbol beats and result beats
// depends on ldr_pkg
`default_nettype none

interface ldr_in_if;
    import ldr_pkg::*;

    logic    valid;
    logic    ready;
    t_sym_in symbol;
    logic    start_req;

    modport source (output valid, output symbol, output start_req, input ready);
    modport sink   (input valid, input symbol, input start_req, output ready);
endinterface

interface ldr_out_if;
    import ldr_pkg::*;

    logic valid;
    logic ready;
    t_len best_len;
    t_len run_len;
    logic overflow;

    modport source (output valid, output best_len, output run_len, output overflow,
                    input ready);
    modport sink   (input valid, input best_len, input run_len, input overflow,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/ldr_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module ldr_ram #(
    parameter int DEPTH     = 256,
    parameter int WIDTH     = 16,
    parameter int ADDR_BITS = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_wr_en,
    input  wire logic [ADDR_BITS-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]     i_wr_data,
    input  wire logic                 i_rd_en,
    input  wire logic [ADDR_BITS-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ldr_seen.sv =====
// per-symbol seen marks in flops, all cleared at once at a new string
// depends on ldr_pkg
`default_nettype none

module ldr_seen (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ldr_pkg::t_seen_req i_req,
    input  wire ldr_pkg::t_sym     i_rd_addr,
    output logic                   o_seen
);
    import ldr_pkg::*;

    logic [ALPHABET-1:0] r_seen;
    logic [ALPHABET-1:0] n_seen;

    // clear on a new string, then mark the current symbol
    always_comb begin
        for (int i = 0; i < ALPHABET; i++) begin
            n_seen[i] = i_req.clr ? 1'b0 : r_seen[i];
            if (i_req.set && (i_req.addr == t_sym'(i))) begin
                n_seen[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else begin
            r_seen <= n_seen;
        end
    end

    assign o_seen = r_seen[i_rd_addr];

endmodule

`default_nettype wire

// ===== hdl/longest_distinct_run.sv =====
// channel     dir  payload                        accepted when
// i_in        in   symbol[7:0], start_req         valid && ready
// o_out       out  best_len, run_len, overflow    valid && ready
//
// one symbol per cycle while o_out is ready; each symbol beat and the registered read of
// the last-position ram feed one update stage, which fills the output register
// a stalled result is held in the output register; one more symbol is still taken
// reset clears the string state and the seen marks at once; the ram needs no clearing
// a same-symbol write/read overlap between neighboring beats is forwarded
// depends on ldr_pkg, ldr_if, ldr_ram, ldr_seen and longest_distinct_run_assert.svh
`default_nettype none

`include "longest_distinct_run_assert.svh"

module longest_distinct_run (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ldr_in_if.sink    i_in,
    ldr_out_if.source o_out
);
    import ldr_pkg::*;

    // update stage
    logic      r_s1_valid;
    t_sym      r_s1_sym;
    logic      r_s1_start;
    logic      r_fwd_hit;
    t_pos      r_fwd_data;

    // string state
    t_pos      r_pos;
    t_pos      r_ws;
    t_pos      r_best;
    logic      r_too_long;

    // output register
    logic      r_out_valid;
    t_len      r_out_best;
    t_len      r_out_run;
    logic      r_out_ovf;

    logic      out_free;
    logic      s1_fire;
    logic      in_fire;
    t_sym      in_sym;
    t_pos      mem_q;
    t_pos      last_pos;
    logic      seen_q;
    logic      seen_e;
    t_pos      pos_e;
    t_pos      ws_e;
    t_pos      best_e;
    logic      ovf_e;
    t_pos      n_ws;
    t_pos      run;
    t_pos      n_best;
    logic      wr_en;
    t_pos      wr_data;
    t_seen_req seen_req;

    // handshakes
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_fire    = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;
    assign in_fire    = i_in.valid && i_in.ready;
    assign in_sym     = fold_sym(i_in.symbol);

    // last position table
    ldr_ram #(
        .DEPTH (ALPHABET),
        .WIDTH (POS_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_sym),
        .i_wr_data (wr_data),
        .i_rd_en   (in_fire),
        .i_rd_addr (in_sym),
        .o_rd_data (mem_q)
    );

    // seen marks
    assign seen_req.clr  = s1_fire && r_s1_start;
    assign seen_req.set  = wr_en;
    assign seen_req.addr = r_s1_sym;

    ldr_seen u_seen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (seen_req),
        .i_rd_addr (r_s1_sym),
        .o_seen    (seen_q)
    );

    // effective state after an optional new-string clear
    assign pos_e    = r_s1_start ? '0 : r_pos;
    assign ws_e     = r_s1_start ? '0 : r_ws;
    assign best_e   = r_s1_start ? '0 : r_best;
    assign seen_e   = r_s1_start ? 1'b0 : seen_q;
    assign ovf_e    = (!r_s1_start && r_too_long) || (&pos_e);
    assign last_pos = r_fwd_hit ? r_fwd_data : mem_q;

    // window move, run length and best run
    always_comb begin
        n_ws = ws_e;
        if (seen_e && (last_pos > ws_e)) begin
            n_ws = last_pos;
        end
        run    = t_pos'(pos_e - n_ws + t_pos'(1));
        n_best = (run > best_e) ? run : best_e;
    end

    assign wr_en   = s1_fire && !ovf_e;
    assign wr_data = t_pos'(pos_e + t_pos'(1));

    // input capture and forwarding of the write in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_sym   <= in_sym;
            r_s1_start <= i_in.start_req;
            r_fwd_hit  <= wr_en && (r_s1_sym == in_sym);
            r_fwd_data <= wr_data;
        end
    end

    // string state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_ws       <= '0;
            r_best     <= '0;
            r_too_long <= 1'b0;
        end else if (s1_fire) begin
            if (ovf_e) begin
                r_pos      <= pos_e;
                r_ws       <= ws_e;
                r_best     <= best_e;
                r_too_long <= 1'b1;
            end else begin
                r_pos      <= wr_data;
                r_ws       <= n_ws;
                r_best     <= n_best;
                r_too_long <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_ovf <= ovf_e;
            if (ovf_e) begin
                r_out_best <= sat_len(best_e);
                r_out_run  <= sat_len(t_pos'(pos_e - ws_e));
            end else begin
                r_out_best <= sat_len(n_best);
                r_out_run  <= sat_len(run);
            end
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.best_len = r_out_best;
    assign o_out.run_len  = r_out_run;
    assign o_out.overflow = r_out_ovf;

    // checks
    `LDR_ASSERT_NOW(a_ws_le_pos, 1'b1, r_ws <= r_pos)
    `LDR_ASSERT_NOW(a_best_covers_run, 1'b1, t_pos'(r_pos - r_ws) <= r_best)
    `LDR_ASSERT_NEXT(a_too_long_sticky, r_too_long && !(s1_fire && r_s1_start), r_too_long)
    `LDR_ASSERT_NOW(a_result_sane, o_out.valid && !o_out.overflow,
                    (o_out.run_len != '0) && (o_out.run_len <= o_out.best_len))

endmodule

`default_nettype wire
